/* rtl/fletcher64_block_checksum_assert.svh */
// assertion macros for the fletcher-64 block checksum
`ifndef FLETCHER64_BLOCK_CHECKSUM_ASSERT_SVH
`define FLETCHER64_BLOCK_CHECKSUM_ASSERT_SVH
`ifndef SYNTHESIS
`define FBC_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
`define FBC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define FBC_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define FBC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* rtl/fbc_pkg.sv */
// shared constants and types for the fletcher-64 block checksum
package fbc_pkg;
   localparam int HALF_W = 32;
   localparam int SUM_W = 64;
   localparam logic [HALF_W-1:0] HALF_ONES = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [SUM_W-1:0] running_sum;
      logic [SUM_W-1:0] sum_of_sums;
      logic [SUM_W-1:0] expected;
   } fin_type;
endpackage

/* rtl/fbc_accumulate.sv */
// input register and running sum accumulators
`include "fletcher64_block_checksum_assert.svh"
module fbc_accumulate (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [31:0]              req_data_word,
   input  logic                     req_last_word,
   input  logic [63:0]              req_expected_checksum,
   output logic                     fin_valid,
   input  logic                     fin_ready,
   output fbc_pkg::fin_type         fin
);
   import fbc_pkg::*;

   logic                 in_vld_ff;
   logic [HALF_W-1:0]    word_ff;
   logic                 last_ff;
   logic [SUM_W-1:0]     exp_ff;
   logic [SUM_W-1:0]     rs_ff;
   logic [SUM_W-1:0]     ss_ff;
   logic                 fin_vld_ff;
   fin_type              fin_ff;

   logic                 fin_room;
   logic                 in_go;
   logic [SUM_W-1:0]     rs_add;
   logic [SUM_W-1:0]     ss_add;
   logic [SUM_W-1:0]     rs_in;
   logic [SUM_W-1:0]     ss_in;
   fin_type              fin_in;

   assign fin_room  = !fin_vld_ff || fin_ready;
   assign in_go     = in_vld_ff && (!last_ff || fin_room);
   assign req_ready = !in_vld_ff || in_go;

   always_comb begin
      rs_add = rs_ff + {{(SUM_W-HALF_W){1'b0}}, word_ff};
      ss_add = ss_ff + rs_ff + {{(SUM_W-HALF_W){1'b0}}, word_ff};
      rs_in  = last_ff ? '0 : rs_add;
      ss_in  = last_ff ? '0 : ss_add;
      fin_in.running_sum = rs_add;
      fin_in.sum_of_sums = ss_add;
      fin_in.expected    = exp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         fin_vld_ff <= 1'b0;
         rs_ff      <= '0;
         ss_ff      <= '0;
      end else begin
         if (req_ready) begin
            in_vld_ff <= req_valid;
         end
         if (fin_room) begin
            fin_vld_ff <= in_go && last_ff;
         end
         if (in_go) begin
            rs_ff <= rs_in;
            ss_ff <= ss_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         word_ff <= req_data_word;
         last_ff <= req_last_word;
         exp_ff  <= req_expected_checksum;
      end
      if (in_go && last_ff) begin
         fin_ff <= fin_in;
      end
   end

   assign fin_valid = fin_vld_ff;
   assign fin       = fin_ff;

   `FBC_ASSERT_NEXT(a_sums_clear, clock, reset, in_go && last_ff, rs_ff == '0 && ss_ff == '0)
   `FBC_ASSERT_NEXT(a_sum_step, clock, reset, in_go && !last_ff, rs_ff == $past(rs_add))
   `FBC_ASSERT_NEXT(a_fin_hold, clock, reset, fin_vld_ff && !fin_ready, fin_vld_ff && $stable(fin_ff))
   `FBC_ASSERT_IMPL(a_ready_full, clock, reset, !req_ready, in_vld_ff && last_ff && !fin_room)

endmodule

/* rtl/fbc_finalize.sv */
// modular folding pipeline forming the two check halves and the compare
module fbc_finalize (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     fin_valid,
   output logic                     fin_ready,
   input  fbc_pkg::fin_type         fin,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [63:0]              rsp_checksum,
   output logic                     rsp_checksum_ok
);
   import fbc_pkg::*;

   localparam int NST = 6;

   function automatic logic [HALF_W:0] fold_add(input logic [SUM_W-1:0] x);
      fold_add = {1'b0, x[SUM_W-1:HALF_W]} + {1'b0, x[HALF_W-1:0]};
   endfunction

   function automatic logic [HALF_W-1:0] fold_finish(input logic [HALF_W:0] m);
      logic [HALF_W-1:0] s;
      s = m[HALF_W-1:0] + {{(HALF_W-1){1'b0}}, m[HALF_W]};
      fold_finish = (s == HALF_ONES) ? HALF_ONES : ~s;
   endfunction

   logic [NST-1:0]       vld_ff;
   logic [NST-1:0]       adv;

   logic [SUM_W-1:0]     t_ff, a_rs_ff, a_exp_ff;
   logic [HALF_W:0]      m1_ff;
   logic [SUM_W-1:0]     b_rs_ff, b_exp_ff;
   logic [HALF_W-1:0]    c1_ff;
   logic [SUM_W-1:0]     c_rs_ff, c_exp_ff;
   logic [SUM_W-1:0]     v_ff, d_exp_ff;
   logic [HALF_W-1:0]    d_c1_ff;
   logic [HALF_W:0]      m2_ff;
   logic [HALF_W-1:0]    e_c1_ff;
   logic [SUM_W-1:0]     e_exp_ff;
   logic [SUM_W-1:0]     sum_ff;
   logic                 ok_ff;

   logic [SUM_W-1:0]     t_in;
   logic [HALF_W:0]      m1_in;
   logic [HALF_W-1:0]    c1_in;
   logic [SUM_W-1:0]     v_in;
   logic [HALF_W:0]      m2_in;
   logic [SUM_W-1:0]     sum_in;
   logic                 ok_in;

   always_comb begin
      adv[NST-1] = !vld_ff[NST-1] || rsp_ready;
      for (int i = NST-2; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
   end

   assign fin_ready = adv[0];

   always_comb begin
      t_in   = fin.running_sum + fin.sum_of_sums;
      m1_in  = fold_add(t_ff);
      c1_in  = fold_finish(m1_ff);
      v_in   = c_rs_ff + {{(SUM_W-HALF_W){1'b0}}, c1_ff};
      m2_in  = fold_add(v_ff);
      sum_in = {fold_finish(m2_ff), e_c1_ff};
      ok_in  = (sum_in == e_exp_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) begin
            vld_ff[0] <= fin_valid;
         end
         for (int i = 1; i < NST; i++) begin
            if (adv[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         t_ff     <= t_in;
         a_rs_ff  <= fin.running_sum;
         a_exp_ff <= fin.expected;
      end
      if (adv[1]) begin
         m1_ff    <= m1_in;
         b_rs_ff  <= a_rs_ff;
         b_exp_ff <= a_exp_ff;
      end
      if (adv[2]) begin
         c1_ff    <= c1_in;
         c_rs_ff  <= b_rs_ff;
         c_exp_ff <= b_exp_ff;
      end
      if (adv[3]) begin
         v_ff     <= v_in;
         d_c1_ff  <= c1_ff;
         d_exp_ff <= c_exp_ff;
      end
      if (adv[4]) begin
         m2_ff    <= m2_in;
         e_c1_ff  <= d_c1_ff;
         e_exp_ff <= d_exp_ff;
      end
      if (adv[5]) begin
         sum_ff <= sum_in;
         ok_ff  <= ok_in;
      end
   end

   assign rsp_valid       = vld_ff[NST-1];
   assign rsp_checksum    = sum_ff;
   assign rsp_checksum_ok = ok_ff;

endmodule

/* rtl/fletcher64_block_checksum.sv */
// fletcher-64 block checksum over 32-bit words, top level
//
//   channel | dir | ports
//   req     | in  | req_data_word[31:0], req_last_word, req_expected_checksum[63:0]
//   rsp     | out | rsp_checksum[63:0], rsp_checksum_ok
//
// one word per cycle unless a last word is held; the 64-bit running sum and sum of sums update once per word
// a result passes through the input register, the hand-off register and six fold stages
// synchronous reset clears both sums and all valid flags
// a stalled rsp fills the fold stages; non-last words keep flowing, a last word
// waits while the hand-off register holds a block the stalled fold stages cannot take
module fletcher64_block_checksum (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [31:0]   req_data_word,
   input  logic          req_last_word,
   input  logic [63:0]   req_expected_checksum,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [63:0]   rsp_checksum,
   output logic          rsp_checksum_ok
);
   import fbc_pkg::*;

   logic      fin_valid;
   logic      fin_ready;
   fin_type   fin;

   fbc_accumulate u_accumulate (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_data_word         (req_data_word),
      .req_last_word         (req_last_word),
      .req_expected_checksum (req_expected_checksum),
      .fin_valid             (fin_valid),
      .fin_ready             (fin_ready),
      .fin                   (fin)
   );

   fbc_finalize u_finalize (
      .clock           (clock),
      .reset           (reset),
      .fin_valid       (fin_valid),
      .fin_ready       (fin_ready),
      .fin             (fin),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_checksum    (rsp_checksum),
      .rsp_checksum_ok (rsp_checksum_ok)
   );

endmodule

/* verif/tb_fletcher64_block_checksum.sv */
// self-checking testbench for the fletcher-64 block checksum: directed table, then random blocks
module tb_fletcher64_block_checksum;
   timeunit 1ns;
   timeprecision 1ps;

   import fbc_pkg::*;

   localparam int          ITEM_TARGET  = 1050;
   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int          DRAIN_CYCLES = 20;
   localparam int          QUIET_FROM   = 300;
   localparam int          QUIET_TO     = 520;

   typedef struct packed {
      logic [31:0]      word;
      logic             lst;
      logic [SUM_W-1:0] exp_in;
      logic             match_exp;
      logic             typed;
      logic [SUM_W-1:0] typed_sum;
      logic             typed_ok;
   } dir_row_type;

   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic             ok;
   } block_result_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [31:0]      req_data_word = '0;
   logic             req_last_word = 1'b0;
   logic [63:0]      req_expected_checksum = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [63:0]      rsp_checksum;
   logic             rsp_checksum_ok;

   logic [SUM_W-1:0] blk_sum = '0;
   logic [SUM_W-1:0] blk_sum_of_sums = '0;
   block_result_type pending_sums[$];
   int               failures = 0;
   int               words_sent = 0;
   bit               quiet = 1'b0;
   int unsigned      cycle_count = 0;

   dir_row_type dir_tab [0:19] = '{
      '{32'h0000_0000, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1},
      '{32'hFFFF_FFFF, 1'b1, 64'h0000_0000_0000_0000, 1'b0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0},
      '{32'h0000_0001, 1'b1, 64'h0000_0001_FFFF_FFFD, 1'b0, 1'b1, 64'h0000_0001_FFFF_FFFD, 1'b1},
      '{32'h0000_0001, 1'b1, 64'h0000_0001_FFFF_FFFC, 1'b0, 1'b1, 64'h0000_0001_FFFF_FFFD, 1'b0},
      '{32'hFFFF_FFFF, 1'b0, 64'h0, 1'b0, 1'b0, 64'h0, 1'b0},
      '{32'hFFFF_FFFF, 1'b0, 64'h0, 1'b0, 1'b0, 64'h0, 1'b0},
      '{32'hFFFF_FFFF, 1'b0, 64'h0, 1'b0, 1'b0, 64'h0, 1'b0},
      '{32'hFFFF_FFFF, 1'b1, 64'h0, 1'b1, 1'b0, 64'h0, 1'b0},
      '{32'h0000_0000, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 64'h0, 1'b0},
      '{32'h0000_0000, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 64'h0, 1'b0},
      '{32'h0000_0000, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1},
      '{32'hAAAA_AAAA, 1'b0, 64'h0, 1'b0, 1'b0, 64'h0, 1'b0},
      '{32'h5555_5555, 1'b0, 64'h0, 1'b0, 1'b0, 64'h0, 1'b0},
      '{32'h8000_0000, 1'b1, 64'hDEAD_BEEF_0123_4567, 1'b0, 1'b0, 64'h0, 1'b0},
      '{32'h1234_5678, 1'b0, 64'h0, 1'b0, 1'b0, 64'h0, 1'b0},
      '{32'h9ABC_DEF0, 1'b0, 64'h0, 1'b0, 1'b0, 64'h0, 1'b0},
      '{32'hFFFF_FFFF, 1'b1, 64'h0, 1'b1, 1'b0, 64'h0, 1'b0},
      '{32'hFFFF_FFFE, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 64'h0, 1'b0},
      '{32'h7FFF_FFFF, 1'b0, 64'h0, 1'b0, 1'b0, 64'h0, 1'b0},
      '{32'h0000_0001, 1'b1, 64'h5555_5555_5555_5555, 1'b0, 1'b0, 64'h0, 1'b0}
   };

   fletcher64_block_checksum dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_data_word         (req_data_word),
      .req_last_word         (req_last_word),
      .req_expected_checksum (req_expected_checksum),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_checksum          (rsp_checksum),
      .rsp_checksum_ok       (rsp_checksum_ok)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // ones-complement style fold of one half
   function automatic logic [HALF_W-1:0] fold_half(input logic [SUM_W-1:0] v);
      logic [SUM_W-1:0] rem;
      rem = v % {{(SUM_W-HALF_W){1'b0}}, HALF_ONES};
      return HALF_ONES - rem[HALF_W-1:0];
   endfunction

   // checksum that closing the block with this word would give
   function automatic logic [SUM_W-1:0] block_checksum_with(input logic [31:0] w);
      logic [SUM_W-1:0] rs;
      logic [SUM_W-1:0] ss;
      logic [HALF_W-1:0] c1;
      logic [HALF_W-1:0] c2;
      rs = blk_sum + {32'h0, w};
      ss = blk_sum_of_sums + rs;
      c1 = fold_half(rs + ss);
      c2 = fold_half(rs + {32'h0, c1});
      return {c2, c1};
   endfunction

   task automatic accept_word(input logic [31:0] w, input logic lst, input logic [63:0] ex,
                              input logic typed, input logic [63:0] typed_sum,
                              input logic typed_ok);
      block_result_type r;
      if (lst) begin
         if (typed) begin
            r.sum = typed_sum;
            r.ok  = typed_ok;
         end else begin
            r.sum = block_checksum_with(w);
            r.ok  = (r.sum == ex);
         end
         pending_sums.push_back(r);
         blk_sum = '0;
         blk_sum_of_sums = '0;
      end else begin
         blk_sum = blk_sum + {32'h0, w};
         blk_sum_of_sums = blk_sum_of_sums + blk_sum;
      end
   endtask

   task automatic send_word(input logic [31:0] w, input logic lst, input logic [63:0] ex,
                            input logic typed, input logic [63:0] typed_sum,
                            input logic typed_ok);
      while (!quiet && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid             <= 1'b1;
      req_data_word         <= w;
      req_last_word         <= lst;
      req_expected_checksum <= ex;
      do @(posedge clock); while (!req_ready);
      accept_word(w, lst, ex, typed, typed_sum, typed_ok);
      words_sent++;
      quiet = (words_sent >= QUIET_FROM) && (words_sent < QUIET_TO);
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(9))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return $urandom_range(255);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int blk_len;
      logic [31:0] w;
      logic [63:0] ex;
      logic lst;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i]) begin
         ex = dir_tab[i].match_exp ? block_checksum_with(dir_tab[i].word) : dir_tab[i].exp_in;
         send_word(dir_tab[i].word, dir_tab[i].lst, ex,
                   dir_tab[i].typed, dir_tab[i].typed_sum, dir_tab[i].typed_ok);
      end

      // random blocks, mostly short, now and then a long one
      while (words_sent < ITEM_TARGET) begin
         blk_len = ($urandom_range(15) == 0) ? $urandom_range(80, 20) : $urandom_range(12, 1);
         for (int k = 0; k < blk_len; k++) begin
            w   = pick_word();
            lst = (k == blk_len - 1);
            case ($urandom_range(9))
               0, 1, 2, 3, 4: ex = block_checksum_with(w);
               9:             ex = block_checksum_with(w) ^ (64'h1 << $urandom_range(63));
               default:       ex = {$urandom, $urandom};
            endcase
            send_word(w, lst, ex, 1'b0, 64'h0, 1'b0);
         end
      end
      req_valid <= 1'b0;

      while (pending_sums.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   always @(posedge clock) begin : rsp_sink
      block_result_type head;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_sums.size() == 0) begin
            $error("unexpected result word: checksum %h ok %b", rsp_checksum, rsp_checksum_ok);
            failures++;
         end else begin
            head = pending_sums.pop_front();
            if (rsp_checksum !== head.sum) begin
               $error("checksum: expected %h, got %h", head.sum, rsp_checksum);
               failures++;
            end
            if (rsp_checksum_ok !== head.ok) begin
               $error("checksum_ok: expected %b, got %b", head.ok, rsp_checksum_ok);
               failures++;
            end
         end
      end
      rsp_ready <= quiet || ($urandom_range(99) >= 11);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

endmodule

/* fletcher64_block_checksum.f */
+incdir+rtl
rtl/fbc_pkg.sv
rtl/fbc_accumulate.sv
rtl/fbc_finalize.sv
rtl/fletcher64_block_checksum.sv
verif/tb_fletcher64_block_checksum.sv
